// ===== design/ctma_pkg.sv =====
// Shared constants and command/status types of the convolution tile MAC accumulator.
package ctma_pkg;

  // Tile geometry and arithmetic widths.
  localparam int CHAN_LANES  = 4;
  localparam int ROW_LANES   = 4;
  localparam int COL_LANES   = 4;
  localparam int ACT_BITS    = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int ACC_BITS    = 40;
  localparam int PROD_BITS   = ACT_BITS + WEIGHT_BITS;

  localparam int TILE_SIZE = CHAN_LANES * ROW_LANES * COL_LANES;
  localparam int ADDR_BITS = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;

  // Configuration port widths.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 10;

  // Configuration register indexes; the last two select no register.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IN_CHANNELS   = 3'd0,
    REG_OUT_CHANNELS  = 3'd1,
    REG_OUT_HEIGHT    = 3'd2,
    REG_OUT_WIDTH     = 3'd3,
    REG_KERNEL_HEIGHT = 3'd4,
    REG_KERNEL_WIDTH  = 3'd5,
    REG_UNUSED_6      = 3'd6,
    REG_UNUSED_7      = 3'd7
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 mac_en;
    logic [ADDR_BITS-1:0] mac_idx;
    logic                 mac_first;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 rd_last;
    logic                 rd_layer;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mac_busy;
    logic rd_free;
  } sts_t;

endpackage

// ===== design/ctma_ifs.sv =====
// Valid/ready channel interfaces for the input pairs, results and configuration writes.
interface ctma_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ctma_pkg::ACT_BITS-1:0]    activation;
  logic signed [ctma_pkg::WEIGHT_BITS-1:0] weight;

  modport source (output valid, output activation, output weight, input ready);
  modport sink (input valid, input activation, input weight, output ready);
endinterface

interface ctma_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ctma_pkg::ACC_BITS-1:0] sum_value;
  logic                                tile_last;
  logic                                layer_last;

  modport source (output valid, output sum_value, output tile_last, output layer_last,
                  input ready);
  modport sink (input valid, input sum_value, input tile_last, input layer_last,
                output ready);
endinterface

interface ctma_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [ctma_pkg::CFG_IDX_BITS-1:0]    index;
  logic [ctma_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/ctma_ctrl.sv =====
// Controller: configuration registers, loop counters, tile sequencing and drain addressing.
module ctma_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  ctma_cfg_if.sink          cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ctma_pkg::sts_t    sts_i,
  output ctma_pkg::cmd_t    cmd_o
);

  localparam int CH_BITS = (ctma_pkg::CHAN_LANES > 1) ? $clog2(ctma_pkg::CHAN_LANES) : 1;
  localparam int RW_BITS = (ctma_pkg::ROW_LANES > 1) ? $clog2(ctma_pkg::ROW_LANES) : 1;
  localparam int CL_BITS = (ctma_pkg::COL_LANES > 1) ? $clog2(ctma_pkg::COL_LANES) : 1;

  localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(ctma_pkg::CHAN_LANES - 1);
  localparam logic [RW_BITS-1:0] RW_LAST = RW_BITS'(ctma_pkg::ROW_LANES - 1);
  localparam logic [CL_BITS-1:0] CL_LAST = CL_BITS'(ctma_pkg::COL_LANES - 1);
  localparam logic [ctma_pkg::ADDR_BITS-1:0] ADDR_LAST =
    ctma_pkg::ADDR_BITS'(ctma_pkg::TILE_SIZE - 1);

  // Controller states.
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // Channel counts saturate at 512, a zero acts as one.
  function automatic logic [9:0] clamp_chan(input logic [9:0] v);
    logic [9:0] r;
    r = v;
    if (v == 10'd0) begin
      r = 10'd1;
    end else if (v > 10'd512) begin
      r = 10'd512;
    end
    return r;
  endfunction

  // Map extents saturate at 256, a zero acts as one.
  function automatic logic [8:0] clamp_dim(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (v > 9'd256) begin
      r = 9'd256;
    end
    return r;
  endfunction

  function automatic logic [2:0] clamp_tap(input logic [2:0] v);
    return (v == 3'd0) ? 3'd1 : v;
  endfunction

  logic [9:0] in_ch_q, out_ch_q;
  logic [8:0] out_h_q, out_w_q;
  logic [2:0] ker_h_q, ker_w_q;

  logic [2:0]         tap_col_q, tap_col_d, tap_row_q, tap_row_d;
  logic [CL_BITS-1:0] lane_col_q, lane_col_d;
  logic [RW_BITS-1:0] lane_row_q, lane_row_d;
  logic [CH_BITS-1:0] lane_chan_q, lane_chan_d;
  logic [8:0]         in_cnt_q, in_cnt_d;
  logic [7:0]         col_base_q, col_base_d, row_base_q, row_base_d;
  logic [9:0]         chan_base_q, chan_base_d;

  logic [1:0]                    state_q, state_d;
  logic [ctma_pkg::ADDR_BITS-1:0] rd_cnt_q, rd_cnt_d;
  logic                          layer_q, layer_d;

  logic mac_en;
  logic tc_wrap, tr_wrap, lx_wrap, lr_wrap, lc_wrap, ic_wrap;
  logic c1, c2, c3, c4, c5, tile_done;
  logic col_end, row_end, chan_end;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= 10'd1;
      out_ch_q <= 10'd1;
      out_h_q  <= 9'd1;
      out_w_q  <= 9'd1;
      ker_h_q  <= 3'd1;
      ker_w_q  <= 3'd1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ctma_pkg::REG_IN_CHANNELS:   in_ch_q  <= clamp_chan(cfg_i.data);
        ctma_pkg::REG_OUT_CHANNELS:  out_ch_q <= clamp_chan(cfg_i.data);
        ctma_pkg::REG_OUT_HEIGHT:    out_h_q  <= clamp_dim(cfg_i.data[8:0]);
        ctma_pkg::REG_OUT_WIDTH:     out_w_q  <= clamp_dim(cfg_i.data[8:0]);
        ctma_pkg::REG_KERNEL_HEIGHT: ker_h_q  <= clamp_tap(cfg_i.data[2:0]);
        ctma_pkg::REG_KERNEL_WIDTH:  ker_w_q  <= clamp_tap(cfg_i.data[2:0]);
        default: begin
        end
      endcase
    end
  end

  // Input pairs are taken only while a tile is open and no drained result still waits for
  // the output register, since a pair reuses the shared read register.
  assign in_ready_o = (state_q == ST_RUN) && sts_i.rd_free;
  assign mac_en     = in_valid_i && in_ready_o;

  // Wrap conditions of the nested loops, innermost first.
  always_comb begin
    tc_wrap = ({1'b0, tap_col_q} + 4'd1) >= {1'b0, ker_w_q};
    tr_wrap = ({1'b0, tap_row_q} + 4'd1) >= {1'b0, ker_h_q};
    lx_wrap = (lane_col_q == CL_LAST);
    lr_wrap = (lane_row_q == RW_LAST);
    lc_wrap = (lane_chan_q == CH_LAST);
    ic_wrap = ({1'b0, in_cnt_q} + 10'd1) >= in_ch_q;
    c1 = tc_wrap;
    c2 = c1 && tr_wrap;
    c3 = c2 && lx_wrap;
    c4 = c3 && lr_wrap;
    c5 = c4 && lc_wrap;
    tile_done = c5 && ic_wrap;
    col_end  = ({2'b0, col_base_q} + 10'(ctma_pkg::COL_LANES)) >= {1'b0, out_w_q};
    row_end  = ({2'b0, row_base_q} + 10'(ctma_pkg::ROW_LANES)) >= {1'b0, out_h_q};
    chan_end = ({1'b0, chan_base_q} + 11'(ctma_pkg::CHAN_LANES)) >= {1'b0, out_ch_q};
  end

  // Next values of the loop counters and tile bases on an accepted pair.
  always_comb begin
    tap_col_d   = tap_col_q;
    tap_row_d   = tap_row_q;
    lane_col_d  = lane_col_q;
    lane_row_d  = lane_row_q;
    lane_chan_d = lane_chan_q;
    in_cnt_d    = in_cnt_q;
    col_base_d  = col_base_q;
    row_base_d  = row_base_q;
    chan_base_d = chan_base_q;
    if (mac_en) begin
      tap_col_d = tc_wrap ? 3'd0 : tap_col_q + 3'd1;
      if (c1) begin
        tap_row_d = tr_wrap ? 3'd0 : tap_row_q + 3'd1;
      end
      if (c2) begin
        lane_col_d = lx_wrap ? '0 : lane_col_q + CL_BITS'(1);
      end
      if (c3) begin
        lane_row_d = lr_wrap ? '0 : lane_row_q + RW_BITS'(1);
      end
      if (c4) begin
        lane_chan_d = lc_wrap ? '0 : lane_chan_q + CH_BITS'(1);
      end
      if (c5) begin
        in_cnt_d = ic_wrap ? 9'd0 : in_cnt_q + 9'd1;
      end
      if (tile_done) begin
        col_base_d = col_end ? 8'd0 : col_base_q + 8'(ctma_pkg::COL_LANES);
        if (col_end) begin
          row_base_d = row_end ? 8'd0 : row_base_q + 8'(ctma_pkg::ROW_LANES);
          if (row_end) begin
            chan_base_d = chan_end ? 10'd0 : chan_base_q + 10'(ctma_pkg::CHAN_LANES);
          end
        end
      end
    end
  end

  // Tile sequencing: run, flush the MAC pipeline, then read the tile out.
  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    layer_d  = layer_q;
    cmd_o.mac_en    = mac_en;
    cmd_o.mac_idx   = ctma_pkg::ADDR_BITS'(
      (int'(lane_chan_q) * ctma_pkg::ROW_LANES + int'(lane_row_q)) * ctma_pkg::COL_LANES
      + int'(lane_col_q));
    cmd_o.mac_first = (tap_col_q == 3'd0) && (tap_row_q == 3'd0);
    cmd_o.rd_en     = 1'b0;
    cmd_o.rd_addr   = rd_cnt_q;
    cmd_o.rd_last   = (rd_cnt_q == ADDR_LAST);
    cmd_o.rd_layer  = layer_q && (rd_cnt_q == ADDR_LAST);
    unique case (state_q)
      ST_RUN: begin
        if (mac_en && tile_done) begin
          state_d = ST_FLUSH;
          layer_d = col_end && row_end && chan_end;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.mac_busy) begin
          state_d  = ST_DRAIN;
          rd_cnt_d = '0;
        end
      end
      ST_DRAIN: begin
        cmd_o.rd_en = sts_i.rd_free;
        if (sts_i.rd_free) begin
          if (rd_cnt_q == ADDR_LAST) begin
            rd_cnt_d = '0;
            state_d  = ST_RUN;
          end else begin
            rd_cnt_d = rd_cnt_q + ctma_pkg::ADDR_BITS'(1);
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      rd_cnt_q    <= '0;
      layer_q     <= 1'b0;
      tap_col_q   <= 3'd0;
      tap_row_q   <= 3'd0;
      lane_col_q  <= '0;
      lane_row_q  <= '0;
      lane_chan_q <= '0;
      in_cnt_q    <= 9'd0;
      col_base_q  <= 8'd0;
      row_base_q  <= 8'd0;
      chan_base_q <= 10'd0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      layer_q     <= layer_d;
      tap_col_q   <= tap_col_d;
      tap_row_q   <= tap_row_d;
      lane_col_q  <= lane_col_d;
      lane_row_q  <= lane_row_d;
      lane_chan_q <= lane_chan_d;
      in_cnt_q    <= in_cnt_d;
      col_base_q  <= col_base_d;
      row_base_q  <= row_base_d;
      chan_base_q <= chan_base_d;
    end
  end

`ifndef SYNTH
  // The last pair of a tile always hands over to the pipeline flush.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mac_en && tile_done) |=> (state_q == ST_FLUSH))
    else $error("tile end did not enter flush");

  // No accumulation may still be in flight while the tile is read out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> !sts_i.mac_busy)
    else $error("drain overlaps MAC pipeline");
`endif

endmodule

// ===== design/ctma_dp.sv =====
// Datapath: multiply-accumulate pipeline, accumulator memory and result output register.
module ctma_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic signed [ctma_pkg::ACT_BITS-1:0]    activation_i,
  input  logic signed [ctma_pkg::WEIGHT_BITS-1:0] weight_i,
  input  ctma_pkg::cmd_t                          cmd_i,
  output ctma_pkg::sts_t                          sts_o,
  ctma_out_if.source                              res_o
);

  // Accumulator memory and its per-entry valid flags.
  logic [ctma_pkg::ACC_BITS-1:0]  acc_mem [ctma_pkg::TILE_SIZE];
  logic [ctma_pkg::TILE_SIZE-1:0] vld_q;

  logic [ctma_pkg::ADDR_BITS-1:0] raddr;
  logic                          rd_any;
  logic [ctma_pkg::ACC_BITS-1:0]  rdata_q;
  logic                          rvld_q;
  logic [ctma_pkg::ACC_BITS-1:0]  rvalue;

  // Multiply stage.
  logic signed [ctma_pkg::ACT_BITS-1:0]    a_q;
  logic signed [ctma_pkg::WEIGHT_BITS-1:0] w_q;
  logic                                   b_valid_q, b_first_q;
  logic [ctma_pkg::ADDR_BITS-1:0]          b_idx_q;

  // Accumulate stage.
  logic signed [ctma_pkg::PROD_BITS-1:0] prod_q;
  logic [ctma_pkg::ACC_BITS-1:0]         c_base_q;
  logic                                 c_valid_q, c_first_q;
  logic [ctma_pkg::ADDR_BITS-1:0]        c_idx_q;
  logic [ctma_pkg::ACC_BITS-1:0]         acc_q;
  logic [ctma_pkg::ACC_BITS-1:0]         sum;

  // Drain path.
  logic                         d_pend_q, d_last_q, d_layer_q;
  logic                         out_valid_q, out_tile_q, out_layer_q;
  logic [ctma_pkg::ACC_BITS-1:0] out_sum_q;
  logic                         mv;

  // One read port shared by the MAC path and the drain.
  assign rd_any = cmd_i.mac_en || cmd_i.rd_en;
  assign raddr  = cmd_i.mac_en ? cmd_i.mac_idx : cmd_i.rd_addr;
  assign rvalue = rvld_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (rd_any) begin
      rdata_q <= acc_mem[raddr];
    end
    if (c_valid_q) begin
      acc_mem[c_idx_q] <= sum;
    end
  end

  // An entry not written since the last drain reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (rd_any) begin
        rvld_q <= vld_q[raddr];
      end
      if (cmd_i.rd_en && cmd_i.rd_last) begin
        vld_q <= '0;
      end else if (c_valid_q) begin
        vld_q[c_idx_q] <= 1'b1;
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      a_q     <= activation_i;
      w_q     <= weight_i;
      b_idx_q <= cmd_i.mac_idx;
    end
    if (b_valid_q) begin
      prod_q   <= a_q * w_q;
      c_base_q <= rvalue;
      c_idx_q  <= b_idx_q;
    end
    if (c_valid_q) begin
      acc_q <= sum;
    end
  end

  // The first pair of a run starts from memory, later pairs from the running sum.
  assign sum = (c_first_q ? c_base_q : acc_q) + ctma_pkg::ACC_BITS'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_first_q <= 1'b0;
      c_valid_q <= 1'b0;
      c_first_q <= 1'b0;
    end else begin
      b_valid_q <= cmd_i.mac_en;
      b_first_q <= cmd_i.mac_first;
      c_valid_q <= b_valid_q;
      c_first_q <= b_first_q;
    end
  end

  // Drain read data moves into the output register whenever that register frees up.
  assign mv = d_pend_q && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_pend_q    <= 1'b0;
      d_last_q    <= 1'b0;
      d_layer_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_tile_q  <= 1'b0;
      out_layer_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        d_pend_q  <= 1'b1;
        d_last_q  <= cmd_i.rd_last;
        d_layer_q <= cmd_i.rd_layer;
      end else if (mv) begin
        d_pend_q <= 1'b0;
      end
      if (mv) begin
        out_valid_q <= 1'b1;
        out_tile_q  <= d_last_q;
        out_layer_q <= d_layer_q;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv) begin
      out_sum_q <= rvalue;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.sum_value  = out_sum_q;
  assign res_o.tile_last  = out_tile_q;
  assign res_o.layer_last = out_layer_q;

  assign sts_o.mac_busy = b_valid_q || c_valid_q;
  assign sts_o.rd_free  = !d_pend_q || mv;

`ifndef SYNTH
  // A drain read never meets an accumulator write still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> !cmd_i.rd_en)
    else $error("drain read during accumulator write");

  // Pending drain data is not overwritten before it reaches the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_pend_q && !mv) |=> (d_pend_q && $stable(rdata_q)))
    else $error("pending drain data lost");
`endif

endmodule

// ===== design/conv_tile_mac_accumulator.sv =====
// Top level: output-stationary convolution tile MAC engine with a 4x4x4 accumulator tile.
// A pair's product passes the multiply and accumulate registers before it lands in its
// accumulator. Throughput: one pair per cycle while a tile is open and the read register is
// free; after a tile's last pair, input stalls for a pipeline flush plus 64 drain reads of
// the accumulator memory (1 per cycle while results are taken).
// Reset (rst_ni, asynchronous, active low) sets the configuration registers to 1 and clears
// counters and flags.
module conv_tile_mac_accumulator (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctma_cfg_if.sink   cfg_i,
  ctma_in_if.sink    in_i,
  ctma_out_if.source res_o
);

  ctma_pkg::cmd_t cmd;
  ctma_pkg::sts_t sts;

  // Controller: counters, configuration and tile sequencing.
  ctma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: MAC pipeline, accumulator memory and output register.
  ctma_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .activation_i (in_i.activation),
    .weight_i     (in_i.weight),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_o        (res_o)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for the convolution tile MAC accumulator: directed table, random phases, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One finished accumulator as it leaves the tile.
  typedef struct {
    logic signed [ctma_pkg::ACC_BITS-1:0] sum;
    logic                                 tile_last;
    logic                                 layer_last;
  } tile_sum_t;

  // One row of the directed stimulus table.
  typedef struct {
    bit                                      is_cfg;
    ctma_pkg::cfg_reg_e                      sel;
    logic [ctma_pkg::CFG_DATA_BITS-1:0]      data;
    logic signed [ctma_pkg::ACT_BITS-1:0]    act;
    logic signed [ctma_pkg::WEIGHT_BITS-1:0] wgt;
    int unsigned                             reps;
    int unsigned                             fixed_cnt;
    logic signed [ctma_pkg::ACC_BITS-1:0]    fixed_sum;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  ctma_cfg_if cfg_bus ();
  ctma_in_if  pair_bus ();
  ctma_out_if sum_bus ();

  conv_tile_mac_accumulator u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (pair_bus),
    .res_o (sum_bus)
  );

  // Shadow of the tile engine: limits, loop counters and accumulators.
  int unsigned lim_in_ch, lim_out_ch, lim_height, lim_width, lim_kh, lim_kw;
  int unsigned tap_col, tap_row, lane_col, lane_row, lane_chan, in_chan_cnt;
  int unsigned col_base, row_base, chan_base;
  logic signed [ctma_pkg::ACC_BITS-1:0] acc_mem [ctma_pkg::TILE_SIZE];

  tile_sum_t                            sum_q [$];
  logic signed [ctma_pkg::ACC_BITS-1:0] fixed_sum_q [$];
  plan_row_t                            plan [$];

  int  fail_cnt = 0;
  bit  no_gaps = 0;
  bit  stall_req = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Step a loop counter; returns 1 when it wrapped back to zero.
  function automatic bit advance(inout int unsigned cnt, input int unsigned limit);
    if (cnt + 1 >= limit) begin
      cnt = 0;
      return 1'b1;
    end
    cnt = cnt + 1;
    return 1'b0;
  endfunction

  function automatic void apply_reg(ctma_pkg::cfg_reg_e sel,
                                    logic [ctma_pkg::CFG_DATA_BITS-1:0] data);
    case (sel)
      ctma_pkg::REG_IN_CHANNELS:   lim_in_ch  = clamp_dim(32'(data), 512);
      ctma_pkg::REG_OUT_CHANNELS:  lim_out_ch = clamp_dim(32'(data), 512);
      ctma_pkg::REG_OUT_HEIGHT:    lim_height = clamp_dim(32'(data[8:0]), 256);
      ctma_pkg::REG_OUT_WIDTH:     lim_width  = clamp_dim(32'(data[8:0]), 256);
      ctma_pkg::REG_KERNEL_HEIGHT: lim_kh     = clamp_dim(32'(data[2:0]), 7);
      ctma_pkg::REG_KERNEL_WIDTH:  lim_kw     = clamp_dim(32'(data[2:0]), 7);
      default: ;
    endcase
  endfunction

  // Accumulate one pair; when it closes a tile, queue the whole tile in lane order.
  function automatic void mac_step(logic signed [ctma_pkg::ACT_BITS-1:0] a,
                                   logic signed [ctma_pkg::WEIGHT_BITS-1:0] w);
    logic signed [ctma_pkg::PROD_BITS-1:0] prod;
    int unsigned                           slot;
    bit                                    layer_end;
    tile_sum_t                             r;
    slot = (lane_chan * ctma_pkg::ROW_LANES + lane_row) * ctma_pkg::COL_LANES + lane_col;
    prod = a * w;
    acc_mem[slot] = acc_mem[slot] + ctma_pkg::ACC_BITS'(prod);
    if (!advance(tap_col, lim_kw)) return;
    if (!advance(tap_row, lim_kh)) return;
    if (!advance(lane_col, ctma_pkg::COL_LANES)) return;
    if (!advance(lane_row, ctma_pkg::ROW_LANES)) return;
    if (!advance(lane_chan, ctma_pkg::CHAN_LANES)) return;
    if (!advance(in_chan_cnt, lim_in_ch)) return;
    // Move the tile origin: columns innermost, then rows, then channels.
    layer_end = 1'b0;
    if (col_base + ctma_pkg::COL_LANES >= lim_width) begin
      col_base = 0;
      if (row_base + ctma_pkg::ROW_LANES >= lim_height) begin
        row_base = 0;
        if (chan_base + ctma_pkg::CHAN_LANES >= lim_out_ch) begin
          chan_base = 0;
          layer_end = 1'b1;
        end else begin
          chan_base = chan_base + ctma_pkg::CHAN_LANES;
        end
      end else begin
        row_base = row_base + ctma_pkg::ROW_LANES;
      end
    end else begin
      col_base = col_base + ctma_pkg::COL_LANES;
    end
    for (int k = 0; k < ctma_pkg::TILE_SIZE; k++) begin
      r.sum        = acc_mem[k];
      r.tile_last  = (k == ctma_pkg::TILE_SIZE - 1);
      r.layer_last = r.tile_last && layer_end;
      // Hand-computed sums from the table take the place of the computed ones.
      if (fixed_sum_q.size() != 0) r.sum = fixed_sum_q.pop_front();
      sum_q.push_back(r);
      acc_mem[k] = '0;
    end
  endfunction

  function automatic void add_cfg(ctma_pkg::cfg_reg_e sel,
                                  logic [ctma_pkg::CFG_DATA_BITS-1:0] data);
    plan_row_t row;
    row = '{is_cfg: 1'b1, sel: sel, data: data, act: '0, wgt: '0, reps: 0,
            fixed_cnt: 0, fixed_sum: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_pairs(logic signed [ctma_pkg::ACT_BITS-1:0] a,
                                    logic signed [ctma_pkg::WEIGHT_BITS-1:0] w,
                                    int unsigned reps, int unsigned fixed_cnt,
                                    logic signed [ctma_pkg::ACC_BITS-1:0] fixed);
    plan_row_t row;
    row = '{is_cfg: 1'b0, sel: ctma_pkg::REG_IN_CHANNELS, data: '0, act: a, wgt: w,
            reps: reps, fixed_cnt: fixed_cnt, fixed_sum: fixed};
    plan.push_back(row);
  endfunction

  task automatic log_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endtask

  // Configuration request; valid drops for a cycle after each write.
  task automatic write_reg(ctma_pkg::cfg_reg_e sel, logic [ctma_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= sel;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    apply_reg(sel, data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Offer one pair after a random gap and hold it until the block takes it.
  task automatic send_pair(logic signed [ctma_pkg::ACT_BITS-1:0] a,
                           logic signed [ctma_pkg::WEIGHT_BITS-1:0] w);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      pair_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pair_bus.valid      <= 1'b1;
    pair_bus.activation <= a;
    pair_bus.weight     <= w;
    do @(posedge clk_i); while (!pair_bus.ready);
    mac_step(a, w);
  endtask

  // Stop offering, wait for every queued result, then let the pipeline settle.
  task automatic wait_drained();
    @(negedge clk_i);
    pair_bus.valid <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // Result side: random gaps per result, and one long hold-off when asked.
  initial begin
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        hold = 300;
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, 8);
      end
      @(negedge clk_i);
      if (hold > 0) begin
        sum_bus.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      sum_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!sum_bus.valid);
    end
  end

  // Scoreboard: each taken result against the oldest expectation.
  always @(posedge clk_i) begin
    tile_sum_t want;
    if (rst_ni && sum_bus.valid && sum_bus.ready) begin
      if (sum_q.size() == 0) begin
        log_fail($sformatf("MISMATCH: unexpected result sum=%0d tile_last=%0b layer_last=%0b",
                           sum_bus.sum_value, sum_bus.tile_last, sum_bus.layer_last));
      end else begin
        want = sum_q.pop_front();
        if (sum_bus.sum_value !== want.sum || sum_bus.tile_last !== want.tile_last ||
            sum_bus.layer_last !== want.layer_last) begin
          log_fail($sformatf({"MISMATCH: expected sum=%0d tile_last=%0b layer_last=%0b, ",
                              "got sum=%0d tile_last=%0b layer_last=%0b"},
                             want.sum, want.tile_last, want.layer_last,
                             sum_bus.sum_value, sum_bus.tile_last, sum_bus.layer_last));
        end
      end
    end
  end

  // Watchdog for a hung handshake or lost results.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    bit                                      prev_cfg;
    int unsigned                             rand_pairs;
    int unsigned                             phase;
    int unsigned                             grow;
    int unsigned                             per_tile;
    int unsigned                             n_pairs;
    logic signed [ctma_pkg::ACT_BITS-1:0]    a;
    logic signed [ctma_pkg::WEIGHT_BITS-1:0] w;

    // Known values on every input from time zero.
    rst_ni              = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = ctma_pkg::REG_IN_CHANNELS;
    cfg_bus.data        = '0;
    pair_bus.valid      = 1'b0;
    pair_bus.activation = '0;
    pair_bus.weight     = '0;
    sum_bus.ready       = 1'b0;

    lim_in_ch = 1; lim_out_ch = 1; lim_height = 1; lim_width = 1; lim_kh = 1; lim_kw = 1;
    tap_col = 0; tap_row = 0; lane_col = 0; lane_row = 0; lane_chan = 0; in_chan_cnt = 0;
    col_base = 0; row_base = 0; chan_base = 0;
    foreach (acc_mem[k]) acc_mem[k] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: one product per accumulator, so each sum is a single product.
    add_pairs(16'sh8000, 16'sh8000, 16, 16, 40'sd1073741824);
    add_pairs(16'sh7FFF, 16'sh7FFF, 16, 16, 40'sd1073676289);
    add_pairs(16'sh8000, 16'sh7FFF, 16, 16, -40'sd1073709056);
    add_pairs(-16'sd1, -16'sd1, 8, 8, 40'sd1);
    add_pairs(16'sd0, 16'sh7FFF, 8, 8, 40'sd0);
    // Two kernel columns: two products per accumulator, cleared from the last tile.
    add_cfg(ctma_pkg::REG_KERNEL_WIDTH, 10'd2);
    add_pairs(16'sh8000, 16'sh8000, 128, 64, 40'sd2147483648);
    // Out-of-range and zero writes, plus the two unused indexes.
    add_cfg(ctma_pkg::REG_IN_CHANNELS, 10'h3FF);
    add_cfg(ctma_pkg::REG_OUT_CHANNELS, 10'h3FF);
    add_cfg(ctma_pkg::REG_OUT_HEIGHT, 10'h1FF);
    add_cfg(ctma_pkg::REG_OUT_WIDTH, 10'd0);
    add_cfg(ctma_pkg::REG_KERNEL_HEIGHT, 10'd0);
    add_cfg(ctma_pkg::REG_KERNEL_WIDTH, 10'd8);
    add_cfg(ctma_pkg::REG_UNUSED_6, 10'h3FF);
    add_cfg(ctma_pkg::REG_UNUSED_7, 10'h155);
    add_pairs(16'sh8000, 16'sh7FFF, 20, 0, '0);
    // Channel limit lowered part way through a tile ends that loop at once.
    add_cfg(ctma_pkg::REG_IN_CHANNELS, 10'd0);
    add_pairs(16'sh7FFF, 16'sh8000, 44, 0, '0);

    // Walk the table; registers only change once the block has gone idle.
    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!prev_cfg) wait_drained();
        write_reg(plan[i].sel, plan[i].data);
      end else begin
        repeat (plan[i].fixed_cnt) fixed_sum_q.push_back(plan[i].fixed_sum);
        no_gaps = (plan[i].reps > 256);
        repeat (plan[i].reps) send_pair(plan[i].act, plan[i].wgt);
      end
      prev_cfg = plan[i].is_cfg;
    end

    // Random phases: fresh geometry, then whole tiles and sometimes a partial one.
    rand_pairs = 0;
    phase = 0;
    while (rand_pairs < 80) begin
      wait_drained();
      no_gaps = ($urandom_range(0, 3) == 0);
      grow = $urandom_range(0, 5);
      per_tile = ctma_pkg::TILE_SIZE * ((grow < 3) ? 2 : 1);
      write_reg(ctma_pkg::REG_IN_CHANNELS,
                (grow == 0) ? 10'd2 : 10'($urandom_range(0, 1)));
      write_reg(ctma_pkg::REG_OUT_CHANNELS,
                $urandom_range(0, 1) ? 10'($urandom_range(1, 12)) : 10'($urandom));
      write_reg(ctma_pkg::REG_OUT_HEIGHT,
                $urandom_range(0, 1) ? 10'($urandom_range(1, 12)) : 10'($urandom));
      write_reg(ctma_pkg::REG_OUT_WIDTH,
                $urandom_range(0, 1) ? 10'($urandom_range(1, 12)) : 10'($urandom));
      write_reg(ctma_pkg::REG_KERNEL_HEIGHT,
                {7'($urandom), (grow == 1) ? 3'd2 : 3'($urandom_range(0, 1))});
      write_reg(ctma_pkg::REG_KERNEL_WIDTH,
                {7'($urandom), (grow == 2) ? 3'd2 : 3'($urandom_range(0, 1))});
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 1) write_reg(ctma_pkg::REG_UNUSED_6, 10'($urandom));
        else write_reg(ctma_pkg::REG_UNUSED_7, 10'($urandom));
      end

      n_pairs = per_tile * ((phase == 0) ? 1 : $urandom_range(1, 2));
      if (phase == 0) begin
        // Long receiver hold-off while pairs keep coming: the drain backs up the input.
        n_pairs = n_pairs + $urandom_range(1, per_tile / 2);
        stall_req = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        n_pairs = n_pairs + $urandom_range(1, per_tile - 1);
      end
      repeat (n_pairs) begin
        a = ctma_pkg::ACT_BITS'($urandom);
        w = ctma_pkg::WEIGHT_BITS'($urandom);
        if ($urandom_range(0, 7) == 0) a = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
        if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
        send_pair(a, w);
      end
      rand_pairs = rand_pairs + n_pairs;
      phase++;
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
